// ===== rtl/fcrpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcrpd_pkg
// Types and constants shared by the framed command relay and PWM decoder.
// ----------------------------------------------------------------------------
package fcrpd_pkg;

   localparam int DUTY_W = 16;
   localparam int PORT_W = 7;
   localparam int CSR_IDX_W = 2;

   // frame bytes
   localparam logic [7:0] B_START  = 8'hAE;
   localparam logic [7:0] B_CTRL   = 8'hAA;
   localparam logic [7:0] B_ALLOFF = 8'hBB;
   localparam logic [7:0] B_ARM    = 8'hCC;
   localparam logic [7:0] B_DATA   = 8'hDD;
   localparam logic [7:0] B_END    = 8'hEE;

   // commands
   localparam logic [7:0] C_PAIR0  = 8'h0C;
   localparam logic [7:0] C_PAIR1  = 8'h0D;
   localparam logic [7:0] C_PAIR2  = 8'h0E;
   localparam logic [7:0] C_SPD_DN = 8'h0A;
   localparam logic [7:0] C_SPD_UP = 8'hA0;
   localparam logic [7:0] C_INT_DN = 8'h0B;
   localparam logic [7:0] C_INT_UP = 8'hB0;

   // port patterns
   localparam logic [PORT_W-1:0] PORT_ALLOFF = 7'h40;
   localparam logic [PORT_W-1:0] PORT_FLASH_KEEP = 7'h47;
   localparam logic [PORT_W-1:0] PORT_PAIR0 = 7'h09;
   localparam logic [PORT_W-1:0] PORT_PAIR1 = 7'h12;
   localparam logic [PORT_W-1:0] PORT_PAIR2 = 7'h24;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_STEP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MAX  = 2'd2;

   localparam logic [DUTY_W-1:0] DUTY_STEP_RST = 16'd2000;
   localparam logic [DUTY_W-1:0] DUTY_MIN_RST  = 16'd1;
   localparam logic [DUTY_W-1:0] DUTY_MAX_RST  = 16'd10001;
   localparam logic [DUTY_W-1:0] DUTY_RST      = 16'd1;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_ZERO_CROSS = 1'b1;

   typedef enum logic [2:0] {
      PS_IDLE     = 3'd0,
      PS_AE       = 3'd1,
      PS_AE_AA    = 3'd2,
      PS_AE_DD    = 3'd3,
      PS_AE_DD_DD = 3'd4,
      PS_CMD      = 3'd5,
      PS_EE       = 3'd6
   } parse_state_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [PORT_W-1:0] port_value;
      logic              flash_pulse;
      logic [DUTY_W-1:0] speed_duty;
      logic [DUTY_W-1:0] intensity_duty;
   } rsp_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_step;
      logic [DUTY_W-1:0] duty_min;
      logic [DUTY_W-1:0] duty_max;
   } cfg_type;

endpackage

// ===== rtl/fcrpd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcrpd_core
// Frame parser, relay port, request flags and duty stepping. State moves on
// each accepted request; the result is the state after that request.
// ----------------------------------------------------------------------------
module fcrpd_core
   import fcrpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type result
);

   parse_state_type   ps_ff, ps_in;
   logic              armed_ff, armed_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic [PORT_W-1:0] port_ff, port_in;
   logic              pend_ff, pend_in;
   logic [3:0]        flags_ff, flags_in;
   logic [DUTY_W-1:0] speed_ff, speed_in;
   logic [DUTY_W-1:0] inten_ff, inten_in;
   logic              flash;

   logic              step_inten;
   logic              step_up;
   logic [DUTY_W-1:0] step_src;
   logic [DUTY_W:0]   step_sum;
   logic [DUTY_W:0]   step_diff;
   logic              step_ok;
   logic [DUTY_W-1:0] step_res;

   // single shared step unit, highest-priority flag picks the operand
   assign step_inten = !flags_ff[0] && !flags_ff[1];
   assign step_up    = flags_ff[0] ? 1'b0 : flags_ff[1] ? 1'b1 : !flags_ff[2];
   assign step_src   = step_inten ? inten_ff : speed_ff;
   assign step_sum   = {1'b0, step_src} + {1'b0, cfg.duty_step};
   assign step_diff  = {1'b0, step_src} - {1'b0, cfg.duty_step};

   always_comb begin
      if (step_up) begin
         step_ok = (step_sum >= {1'b0, cfg.duty_min}) && (step_sum <= {1'b0, cfg.duty_max});
      end else begin
         step_ok = !step_diff[DUTY_W] && (step_diff[DUTY_W-1:0] >= cfg.duty_min)
                   && (step_diff[DUTY_W-1:0] <= cfg.duty_max);
      end
      if (!step_ok) begin
         step_res = step_src;
      end else if (step_up) begin
         step_res = step_sum[DUTY_W-1:0];
      end else begin
         step_res = step_diff[DUTY_W-1:0];
      end
   end

   always_comb begin
      parse_state_type s;
      logic [7:0]      b;
      s        = ps_ff;
      b        = req.rx_byte;
      ps_in    = ps_ff;
      armed_in = armed_ff;
      cmd_in   = cmd_ff;
      port_in  = port_ff;
      pend_in  = pend_ff;
      flags_in = flags_ff;
      speed_in = speed_ff;
      inten_in = inten_ff;
      flash    = 1'b0;
      if (req.opcode == OP_ZERO_CROSS) begin
         if (pend_ff) begin
            pend_in  = 1'b0;
            flags_in = flags_ff & (flags_ff - 4'd1);
            if (flags_ff != 4'd0) begin
               if (step_inten) begin
                  inten_in = step_res;
               end else begin
                  speed_in = step_res;
               end
            end
         end
      end else begin
         if (!armed_ff && (s == PS_AE_DD || s == PS_AE_DD_DD || s == PS_CMD || s == PS_EE)) begin
            s = PS_IDLE;
         end
         ps_in = PS_IDLE;
         case (s)
            PS_IDLE: begin
               if (b == B_START) ps_in = PS_AE;
            end
            PS_AE: begin
               if (b == B_CTRL) begin
                  ps_in = PS_AE_AA;
               end else if (armed_ff && b == B_DATA) begin
                  ps_in = PS_AE_DD;
               end
            end
            PS_AE_AA: begin
               if (b == B_ALLOFF) begin
                  port_in = PORT_ALLOFF;
               end else if (!armed_ff && b == B_ARM) begin
                  port_in  = port_ff & PORT_FLASH_KEEP;
                  armed_in = 1'b1;
                  flash    = 1'b1;
               end
            end
            PS_AE_DD: begin
               if (b == B_DATA) ps_in = PS_AE_DD_DD;
            end
            PS_AE_DD_DD: begin
               cmd_in = b;
               ps_in  = PS_CMD;
            end
            PS_CMD: begin
               if (b == B_END) ps_in = PS_EE;
            end
            PS_EE: begin
               if (b == B_END) begin
                  case (cmd_ff)
                     C_PAIR0: port_in = port_ff ^ PORT_PAIR0;
                     C_PAIR1: port_in = port_ff ^ PORT_PAIR1;
                     C_PAIR2: port_in = port_ff ^ PORT_PAIR2;
                     C_SPD_DN: begin
                        pend_in  = 1'b1;
                        flags_in = flags_ff | 4'b0001;
                     end
                     C_SPD_UP: begin
                        pend_in  = 1'b1;
                        flags_in = flags_ff | 4'b0010;
                     end
                     C_INT_DN: begin
                        pend_in  = 1'b1;
                        flags_in = flags_ff | 4'b0100;
                     end
                     C_INT_UP: begin
                        pend_in  = 1'b1;
                        flags_in = flags_ff | 4'b1000;
                     end
                     default: ;
                  endcase
               end
            end
            default: begin
               if (b == B_START) ps_in = PS_AE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff    <= PS_IDLE;
         armed_ff <= 1'b0;
         cmd_ff   <= 8'd0;
         port_ff  <= '0;
         pend_ff  <= 1'b0;
         flags_ff <= 4'd0;
         speed_ff <= DUTY_RST;
         inten_ff <= DUTY_RST;
      end else if (accept) begin
         ps_ff    <= ps_in;
         armed_ff <= armed_in;
         cmd_ff   <= cmd_in;
         port_ff  <= port_in;
         pend_ff  <= pend_in;
         flags_ff <= flags_in;
         speed_ff <= speed_in;
         inten_ff <= inten_in;
      end
   end

   assign result.port_value     = port_in;
   assign result.flash_pulse    = flash;
   assign result.speed_duty     = speed_in;
   assign result.intensity_duty = inten_in;

   // once armed, stays armed
   a_armed_sticky: assert property (@(posedge clock) disable iff (reset)
      armed_ff |=> armed_ff)
      else $error("armed flag cleared");

   // a pending request always has a flag behind it
   a_pend_flags: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (flags_ff != 4'd0))
      else $error("pending request without flag");

   // a flash leaves bits 3-5 low
   a_flash_port: assert property (@(posedge clock) disable iff (reset)
      (accept && flash) |=> (port_ff[5:3] == 3'd0) && armed_ff)
      else $error("flash left port bits set");

endmodule

// ===== rtl/framed_command_relay_pwm_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_relay_pwm_decoder
// Parses framed command bytes and zero-cross events, drives the relay port
// and steps the speed and intensity duty values.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  req      in   req_valid/req_stall   req_data   (req_type)
//  rsp      out  rsp_valid/rsp_stall   rsp_data   (rsp_type)
//  csr      in   csr_we                csr_index, csr_wdata
//
// One request per cycle while req_stall is low, one result per request.
// The parser and the single step adder settle within the accept cycle.
// A two-entry output buffer holds results; req_stall rises only when both
// entries are full. Synchronous reset restores all but the result data.
// ----------------------------------------------------------------------------
module framed_command_relay_pwm_decoder
   import fcrpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DUTY_W-1:0]    csr_wdata
);

   cfg_type cfg_ff;
   rsp_type result;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_valid_ff;
   logic    skid_valid_ff;
   logic    push;
   logic    pop;

   assign req_stall = skid_valid_ff;
   assign push      = req_valid && !req_stall;
   assign pop       = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_step <= DUTY_STEP_RST;
         cfg_ff.duty_min  <= DUTY_MIN_RST;
         cfg_ff.duty_max  <= DUTY_MAX_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DUTY_STEP: cfg_ff.duty_step <= csr_wdata;
            CSR_DUTY_MIN:  cfg_ff.duty_min  <= csr_wdata;
            CSR_DUTY_MAX:  cfg_ff.duty_max  <= csr_wdata;
            default: ;
         endcase
      end
   end

   fcrpd_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (push),
      .req    (req_data),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (pop) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (push) begin
            if (out_valid_ff && !pop) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) out_ff <= skid_ff;
      end else if (push) begin
         if (out_valid_ff && !pop) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without head entry");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && push) |=> skid_valid_ff)
      else $error("request lost while output stalled");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid entry not moved to head");

endmodule

// ===== test/framed_command_relay_pwm_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_relay_pwm_decoder_checker
// Watches the request, result and register ports of the decoder. It tracks
// the frame parser, relay port and duty values in its own copy of the state,
// queues the result due for every accepted request and compares each
// delivered result with the oldest one queued.
// ----------------------------------------------------------------------------
module framed_command_relay_pwm_decoder_checker
   import fcrpd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DUTY_W-1:0]    csr_wdata,
   output int                   mismatch_count,
   output int                   outstanding,
   output int                   checked_count
);

   cfg_type           duty_cfg;
   parse_state_type   frame_state;
   logic              armed;
   logic [7:0]        held_cmd;
   logic [PORT_W-1:0] relay_port;
   logic              step_due;
   logic [3:0]        step_flags;
   logic [DUTY_W-1:0] speed_duty;
   logic [DUTY_W-1:0] intensity_duty;
   rsp_type           due_results[$];
   int                n_fail = 0;
   int                n_checked = 0;

   initial begin
      mismatch_count = 0;
      outstanding = 0;
      checked_count = 0;
   end

   function automatic logic [DUTY_W-1:0] stepped_duty(input logic [DUTY_W-1:0] v,
                                                      input logic up);
      int n;
      n = up ? int'(v) + int'(duty_cfg.duty_step) : int'(v) - int'(duty_cfg.duty_step);
      if (n < int'(duty_cfg.duty_min) || n > int'(duty_cfg.duty_max))
         return v;
      return n[DUTY_W-1:0];
   endfunction

   function automatic void run_command(input logic [7:0] c);
      case (c)
         C_PAIR0:  relay_port ^= PORT_PAIR0;
         C_PAIR1:  relay_port ^= PORT_PAIR1;
         C_PAIR2:  relay_port ^= PORT_PAIR2;
         C_SPD_DN: begin step_due = 1'b1; step_flags[0] = 1'b1; end
         C_SPD_UP: begin step_due = 1'b1; step_flags[1] = 1'b1; end
         C_INT_DN: begin step_due = 1'b1; step_flags[2] = 1'b1; end
         C_INT_UP: begin step_due = 1'b1; step_flags[3] = 1'b1; end
         default: ;
      endcase
   endfunction

   // one queued request per zero crossing, lowest flag first
   function automatic void serve_zero_cross();
      if (!step_due)
         return;
      step_due = 1'b0;
      if (step_flags[0]) begin
         step_flags[0] = 1'b0;
         speed_duty = stepped_duty(speed_duty, 1'b0);
      end else if (step_flags[1]) begin
         step_flags[1] = 1'b0;
         speed_duty = stepped_duty(speed_duty, 1'b1);
      end else if (step_flags[2]) begin
         step_flags[2] = 1'b0;
         intensity_duty = stepped_duty(intensity_duty, 1'b0);
      end else if (step_flags[3]) begin
         step_flags[3] = 1'b0;
         intensity_duty = stepped_duty(intensity_duty, 1'b1);
      end
   endfunction

   function automatic logic parse_byte(input logic [7:0] b);
      logic            flash;
      parse_state_type s;
      parse_state_type nxt;
      flash = 1'b0;
      s = frame_state;
      if (!armed && s > PS_AE_AA)
         s = PS_IDLE;
      nxt = PS_IDLE;
      case (s)
         PS_IDLE: begin
            if (b == B_START)
               nxt = PS_AE;
         end
         PS_AE: begin
            if (b == B_CTRL)
               nxt = PS_AE_AA;
            else if (armed && b == B_DATA)
               nxt = PS_AE_DD;
         end
         PS_AE_AA: begin
            if (b == B_ALLOFF) begin
               relay_port = PORT_ALLOFF;
            end else if (!armed && b == B_ARM) begin
               relay_port &= PORT_FLASH_KEEP;
               armed = 1'b1;
               flash = 1'b1;
            end
         end
         PS_AE_DD: begin
            if (b == B_DATA)
               nxt = PS_AE_DD_DD;
         end
         PS_AE_DD_DD: begin
            held_cmd = b;
            nxt = PS_CMD;
         end
         PS_CMD: begin
            if (b == B_END)
               nxt = PS_EE;
         end
         default: begin
            if (b == B_END)
               run_command(held_cmd);
         end
      endcase
      frame_state = nxt;
      return flash;
   endfunction

   function automatic rsp_type decode_request(input req_type r);
      rsp_type o;
      o.flash_pulse = 1'b0;
      if (r.opcode == OP_ZERO_CROSS)
         serve_zero_cross();
      else
         o.flash_pulse = parse_byte(r.rx_byte);
      o.port_value = relay_port;
      o.speed_duty = speed_duty;
      o.intensity_duty = intensity_duty;
      return o;
   endfunction

   always @(posedge clock) begin : track
      rsp_type want;
      rsp_type got;
      if (reset) begin
         duty_cfg.duty_step = DUTY_STEP_RST;
         duty_cfg.duty_min = DUTY_MIN_RST;
         duty_cfg.duty_max = DUTY_MAX_RST;
         frame_state = PS_IDLE;
         armed = 1'b0;
         held_cmd = '0;
         relay_port = '0;
         step_due = 1'b0;
         step_flags = '0;
         speed_duty = DUTY_RST;
         intensity_duty = DUTY_RST;
         due_results.delete();
      end else begin
         if (req_valid && !req_stall)
            due_results.push_back(decode_request(req_data));
         // a register write takes effect after this edge
         if (csr_we) begin
            case (csr_index)
               CSR_DUTY_STEP: duty_cfg.duty_step = csr_wdata;
               CSR_DUTY_MIN:  duty_cfg.duty_min = csr_wdata;
               CSR_DUTY_MAX:  duty_cfg.duty_max = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (due_results.size() == 0) begin
               if (n_fail < 10)
                  $display("unexpected result: port %h flash %b speed %0d intensity %0d",
                           got.port_value, got.flash_pulse, got.speed_duty,
                           got.intensity_duty);
               n_fail++;
            end else begin
               want = due_results.pop_front();
               n_checked++;
               if (want.port_value !== got.port_value
                   || want.flash_pulse !== got.flash_pulse
                   || want.speed_duty !== got.speed_duty
                   || want.intensity_duty !== got.intensity_duty) begin
                  if (n_fail < 10)
                     $display({"mismatch on result %0d (expected/actual): port %h/%h ",
                               "flash %b/%b speed %0d/%0d intensity %0d/%0d"},
                              n_checked, want.port_value, got.port_value,
                              want.flash_pulse, got.flash_pulse,
                              want.speed_duty, got.speed_duty,
                              want.intensity_duty, got.intensity_duty);
                  n_fail++;
               end
            end
         end
      end
      outstanding <= due_results.size();
      mismatch_count <= n_fail;
      checked_count <= n_checked;
   end

endmodule

// ===== test/framed_command_relay_pwm_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_relay_pwm_decoder_tb
// Drives byte and zero-cross requests into the decoder through several
// phases of duty settings and idling, with a long result hold-off, and
// reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module framed_command_relay_pwm_decoder_tb;
   import fcrpd_pkg::*;

   localparam int LONG_HOLD = 150;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DUTY_W-1:0]    csr_wdata = '0;

   int mismatch_count;
   int outstanding;
   int checked_count;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_asked = 0;
   int hold_done = 0;
   int sent = 0;
   int cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   framed_command_relay_pwm_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   framed_command_relay_pwm_decoder_checker rsp_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver: random stalls, or one long hold when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic offer(input logic op, input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{opcode: op, rx_byte: b};
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic frame(input logic [7:0] c);
      offer(OP_BYTE, B_START);
      offer(OP_BYTE, B_DATA);
      offer(OP_BYTE, B_DATA);
      offer(OP_BYTE, c);
      offer(OP_BYTE, B_END);
      offer(OP_BYTE, B_END);
   endtask

   task automatic ctrl(input logic [7:0] b);
      offer(OP_BYTE, B_START);
      offer(OP_BYTE, B_CTRL);
      offer(OP_BYTE, b);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic load_duty(input logic [DUTY_W-1:0] stp, input logic [DUTY_W-1:0] mn,
                            input logic [DUTY_W-1:0] mx);
      csr_we <= 1'b1;
      csr_index <= CSR_DUTY_STEP;
      csr_wdata <= stp;
      @(posedge clock);
      csr_index <= CSR_DUTY_MIN;
      csr_wdata <= mn;
      @(posedge clock);
      csr_index <= CSR_DUTY_MAX;
      csr_wdata <= mx;
      @(posedge clock);
      csr_index <= CSR_SPARE;
      csr_wdata <= DUTY_W'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_traffic(input int n);
      int         start;
      int         k;
      int         cut;
      logic [7:0] c;
      logic [7:0] seq[6];
      start = sent;
      while (sent - start < n) begin
         k = $urandom_range(99);
         case ($urandom_range(7))
            0: c = C_PAIR0;
            1: c = C_PAIR1;
            2: c = C_PAIR2;
            3: c = C_SPD_DN;
            4: c = C_SPD_UP;
            5: c = C_INT_DN;
            6: c = C_INT_UP;
            default: c = 8'($urandom);
         endcase
         if (k < 35) begin
            frame(c);
         end else if (k < 42) begin
            ctrl(B_ALLOFF);
         end else if (k < 45) begin
            ctrl(B_ARM);
         end else if (k < 48) begin
            ctrl(8'($urandom));
         end else if (k < 72) begin
            offer(OP_ZERO_CROSS, 8'($urandom));
         end else if (k < 87) begin
            // frame cut short by a stray byte
            seq = '{B_START, B_DATA, B_DATA, c, B_END, B_END};
            cut = $urandom_range(1, 5);
            for (int i = 0; i < cut; i++)
               offer(OP_BYTE, seq[i]);
            offer(OP_BYTE, 8'($urandom));
         end else begin
            offer(1'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: unarmed behaviour, arming, dropped bytes, step undone
      offer(OP_BYTE, 8'h00);
      offer(OP_ZERO_CROSS, 8'hFF);
      offer(OP_BYTE, B_START);
      offer(OP_BYTE, B_START);
      offer(OP_BYTE, B_CTRL);
      offer(OP_BYTE, B_ALLOFF);
      offer(OP_BYTE, B_START);
      offer(OP_BYTE, B_DATA);
      ctrl(B_ARM);
      ctrl(B_ARM);
      frame(C_SPD_DN);
      offer(OP_ZERO_CROSS, 8'h00);
      frame(8'hFF);
      random_traffic(300);
      settle();

      load_duty(16'd1, 16'd0, 16'hFFFF);
      idle_pct = 57;
      stall_pct = 0;
      random_traffic(300);
      settle();

      load_duty(16'hFFFF, 16'd0, 16'hFFFF);
      idle_pct = 0;
      stall_pct = 57;
      random_traffic(300);
      settle();

      load_duty(DUTY_W'($urandom_range(1, 3000)), DUTY_W'($urandom_range(0, 2000)),
                DUTY_W'($urandom_range(5000, 65535)));
      idle_pct = 24;
      stall_pct = 24;
      random_traffic(300);
      settle();

      // zero step with inverted bounds, results held off while requests pile up
      load_duty(16'd0, 16'hFFFF, 16'd0);
      idle_pct = 0;
      stall_pct = 0;
      hold_asked++;
      random_traffic(300);
      settle();

      load_duty(16'd12345, 16'd0, 16'hFFFF);
      idle_pct = 24;
      stall_pct = 24;
      random_traffic(450);
      settle();

      $display("covered %0d requests over six phases, %0d results checked", sent,
               checked_count);
      $display("duty settings: reset, unit step, full step, random, zero step inverted, wide");
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/fcrpd_pkg.sv
rtl/fcrpd_core.sv
rtl/framed_command_relay_pwm_decoder.sv
test/framed_command_relay_pwm_decoder_checker.sv
test/framed_command_relay_pwm_decoder_tb.sv
